### src/sfla_pkg.sv
// shared types and constants for the slot free-list allocator
package sfla_pkg;

    // request field widths
    localparam int OP_W   = 1;
    localparam int SLOT_W = 8;
    // result field widths
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 8;

    // stream payload widths
    localparam int S_DATA_W = 8;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 24;

    // request opcodes
    localparam logic [OP_W-1:0] OP_ALLOC = 1'b0;
    localparam logic [OP_W-1:0] OP_FREE  = 1'b1;

    // result status codes
    localparam logic [STAT_W-1:0] STAT_DONE     = 2'd0;
    localparam logic [STAT_W-1:0] STAT_NO_SPACE = 2'd1;
    localparam logic [STAT_W-1:0] STAT_IGNORED  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic accept;  // latch request, launch memory reads
        logic commit;  // update state, load result register
    } dp_cmd_t;

endpackage

### src/sfla_ctrl.sv
// controller state machine: request sequencing and result handshake
module sfla_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output sfla_pkg::dp_cmd_t cmd
);

    sfla_pkg::state_t state_reg, state_next;
    logic             m_valid_reg, m_valid_next;
    logic             out_free;

    assign s_tready   = (state_reg == sfla_pkg::ST_IDLE);
    assign out_free   = !m_valid_reg || m_tready;
    assign cmd.accept = s_tvalid && s_tready;
    assign cmd.commit = (state_reg == sfla_pkg::ST_EXEC) && out_free;
    assign m_tvalid   = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sfla_pkg::ST_IDLE: begin
                if (cmd.accept) begin
                    state_next = sfla_pkg::ST_EXEC;
                end
            end
            sfla_pkg::ST_EXEC: begin
                if (cmd.commit) begin
                    state_next = sfla_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = sfla_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= sfla_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

### src/sfla_dp.sv
// allocator datapath: link and mark memories, list registers, result register
module sfla_dp #(
    parameter int SLOTS = 256
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  sfla_pkg::dp_cmd_t              cmd,
    input  logic [sfla_pkg::OP_W-1:0]      opcode_i,
    input  logic [sfla_pkg::SLOT_W-1:0]    slot_index_i,
    output logic [sfla_pkg::SLOT_W-1:0]    granted_slot_o,
    output logic [sfla_pkg::STAT_W-1:0]    status_o,
    output logic [sfla_pkg::COUNT_W-1:0]   live_count_o
);

    localparam int IDX_W = $clog2(SLOTS);
    localparam int W     = (IDX_W > sfla_pkg::SLOT_W) ? IDX_W : sfla_pkg::SLOT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

    logic [IDX_W-1:0] next_link_mem [SLOTS];
    logic             free_mark_mem [SLOTS];

    logic [sfla_pkg::OP_W-1:0]   op_reg;
    logic [sfla_pkg::SLOT_W-1:0] idx_reg;
    logic [IDX_W-1:0]            link_rd_reg;
    logic                        mark_rd_reg;

    logic [IDX_W-1:0] head_reg, head_next;
    logic             nonempty_reg, nonempty_next;
    logic [IDX_W-1:0] hw_reg, hw_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;

    logic [sfla_pkg::SLOT_W-1:0]  granted_reg;
    logic [sfla_pkg::STAT_W-1:0]  status_reg;
    logic [sfla_pkg::COUNT_W-1:0] live_reg;

    logic [W-1:0]     in_idx_w, idx_w, hw_w, slot_w, cnt_w;
    logic [IDX_W-1:0] in_addr, idx_addr;
    logic [IDX_W-1:0] slot;
    logic [sfla_pkg::STAT_W-1:0] stat;
    logic             link_we, mark_we, mark_wdata;
    logic [IDX_W-1:0] link_wdata, mark_waddr;

    assign in_idx_w = W'(slot_index_i);
    assign in_addr  = in_idx_w[IDX_W-1:0];
    assign idx_w    = W'(idx_reg);
    assign idx_addr = idx_w[IDX_W-1:0];
    assign hw_w     = W'(hw_reg);
    assign slot_w   = W'(slot);
    assign cnt_w    = W'(cnt_next);

    // link memory: read at the list head when a request comes in
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            link_rd_reg <= next_link_mem[head_reg];
        end
        if (cmd.commit && link_we) begin
            next_link_mem[idx_addr] <= link_wdata;
        end
    end

    // free marks: valid only below the high-water mark, cleared whenever a slot is allocated
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            mark_rd_reg <= free_mark_mem[in_addr];
        end
        if (cmd.commit && mark_we) begin
            free_mark_mem[mark_waddr] <= mark_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg  <= opcode_i;
            idx_reg <= slot_index_i;
        end
    end

    always_comb begin
        head_next     = head_reg;
        nonempty_next = nonempty_reg;
        hw_next       = hw_reg;
        cnt_next      = cnt_reg;
        link_we       = 1'b0;
        link_wdata    = idx_addr;
        mark_we       = 1'b0;
        mark_waddr    = idx_addr;
        mark_wdata    = 1'b0;
        slot          = '0;
        stat          = sfla_pkg::STAT_DONE;
        if (op_reg == sfla_pkg::OP_ALLOC) begin
            if (nonempty_reg) begin
                // pop the list head; the tail links to itself
                slot       = head_reg;
                mark_we    = 1'b1;
                mark_waddr = head_reg;
                cnt_next   = IDX_W'(cnt_reg + 1'b1);
                if (link_rd_reg == head_reg) begin
                    nonempty_next = 1'b0;
                    head_next     = '0;
                end else begin
                    head_next = link_rd_reg;
                end
            end else if (hw_reg >= LAST_IDX) begin
                stat = sfla_pkg::STAT_NO_SPACE;
            end else begin
                slot       = hw_reg;
                hw_next    = IDX_W'(hw_reg + 1'b1);
                mark_we    = 1'b1;
                mark_waddr = hw_reg;
                cnt_next   = IDX_W'(cnt_reg + 1'b1);
            end
        end else begin
            if (idx_w == '0 || idx_w >= hw_w || mark_rd_reg) begin
                stat = sfla_pkg::STAT_IGNORED;
            end else begin
                mark_we       = 1'b1;
                mark_wdata    = 1'b1;
                link_we       = 1'b1;
                link_wdata    = nonempty_reg ? head_reg : idx_addr;
                head_next     = idx_addr;
                nonempty_next = 1'b1;
                if (cnt_reg != '0) begin
                    cnt_next = IDX_W'(cnt_reg - 1'b1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg     <= '0;
            nonempty_reg <= 1'b0;
            hw_reg       <= '0;
            cnt_reg      <= '0;
        end else if (cmd.commit) begin
            head_reg     <= head_next;
            nonempty_reg <= nonempty_next;
            hw_reg       <= hw_next;
            cnt_reg      <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            granted_reg <= slot_w[sfla_pkg::SLOT_W-1:0];
            status_reg  <= stat;
            live_reg    <= cnt_w[sfla_pkg::COUNT_W-1:0];
        end
    end

    assign granted_slot_o = granted_reg;
    assign status_o       = status_reg;
    assign live_count_o   = live_reg;

endmodule

### src/slot_free_list_allocator_top.sv
// top level of the slot free-list allocator
//
// hands out slot indices 0 to SLOTS-2 from a pool of SLOTS entries, one per request item
// input channel s_*: s_tuser carries the opcode (0 allocate, 1 free),
//   s_tdata carries the slot index to free (ignored on allocate)
// result channel m_*: exactly one result item per request item with the
//   granted slot, a status code (done, out of space, free ignored) and the
//   number of live slots after the request
// allocate pops the freed-slot list first, then takes fresh indices from a
//   high-water counter; free pushes a slot back onto the list head
// a result item is loaded into the result register in ST_EXEC once the output is free;
//   requests are taken one at a time, s_tready is low while one executes; the list
//   pop reads the head's link from the link memory into a register on accept
// reset: list empty, high-water mark and live count at zero; no memory
//   clearing pass is needed, memory contents are only used below the high-water mark
// stall: the result register holds while m_tready is low; one further request
//   is taken and then waits until the result register can be loaded
module slot_free_list_allocator_top #(
    parameter int SLOTS = 256
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request items
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [sfla_pkg::S_DATA_W-1:0]   s_tdata,   // [7:0] slot_index
    input  logic [sfla_pkg::S_USER_W-1:0]   s_tuser,   // [0] opcode
    // result items
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [sfla_pkg::M_DATA_W-1:0]   m_tdata    // [7:0] granted_slot,
                                                       // [9:8] status,
                                                       // [17:10] live_count
);

    sfla_pkg::dp_cmd_t cmd;

    logic [sfla_pkg::SLOT_W-1:0]  granted_slot;
    logic [sfla_pkg::STAT_W-1:0]  status;
    logic [sfla_pkg::COUNT_W-1:0] live_count;

    // handshake sequencing
    sfla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // list state, memories and result register
    sfla_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .opcode_i       (s_tuser),
        .slot_index_i   (s_tdata),
        .granted_slot_o (granted_slot),
        .status_o       (status),
        .live_count_o   (live_count)
    );

    // pack result fields, low field first, zero fill to whole bytes
    assign m_tdata = {6'd0, live_count, status, granted_slot};

`ifndef ASSERT_OFF
    // one request in flight: no new item the cycle after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while previous one in flight");

    // a failed request never grants a slot
    a_fail_no_grant: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (status == sfla_pkg::STAT_NO_SPACE
                      || status == sfla_pkg::STAT_IGNORED)) |-> (granted_slot == '0))
        else $error("failed request carries a granted slot");

    // a result appears only after a request was taken
    a_result_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result without a request in flight");
`endif

endmodule
